FILE: rtl/wvde_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wvde_pkg
// Shared types, widths and codes for the wind vane direction estimator.
// ----------------------------------------------------------------------------
package wvde_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int MV_W       = 16;
  localparam int OHMS_W     = 24;
  localparam int IDX_W      = 4;
  localparam int TENTHS_W   = 12;
  localparam int SUM_W      = 26;
  localparam int CFG_W      = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int RES_W      = 20;
  localparam int SUPPLY_W   = 13;
  localparam int FS_W       = 12;
  localparam int NUM_W      = 39;
  localparam int ENTRIES    = 16;
  localparam int SCNT_W     = 5;
  localparam int PROD_W     = 31;

  localparam int DEF_MAX_SAMPLES = 1024;
  localparam int DEF_DIRECTIONS  = 16;

  localparam logic [14:0]         A1_Q15          = 15'd30218;
  localparam logic [7:0]          TENTHS_PER_STEP = 8'd225;
  localparam logic [MV_W-1:0]     MV_MAX          = 16'hFFFF;
  localparam logic [OHMS_W-1:0]   OHMS_MAX        = 24'hFFFFFF;

  localparam logic [CFG_IDX_W-1:0] CFG_SERIES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SUPPLY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REF    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FS     = 2'd3;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_ENTRY  = 1'b1;

  typedef struct packed {
    logic                kind;
    logic [SAMPLE_W-1:0] sample_code;
    logic                last_sample;
    logic [IDX_W-1:0]    entry_index;
    logic [OHMS_W-1:0]   entry_ohms;
  } in_item_t;

  typedef struct packed {
    logic [MV_W-1:0]     mean_millivolts;
    logic [OHMS_W-1:0]   vane_ohms;
    logic [IDX_W-1:0]    direction_index;
    logic [TENTHS_W-1:0] direction_tenths;
    logic                over_supply;
  } out_item_t;

  typedef struct packed {
    logic tbl_we;
    logic smp_load;
    logic filt_acc;
    logic mean_mul;
    logic div_start;
    logic mean_load;
    logic ohms_mul;
    logic ohms_load;
    logic srch_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic in_kind;
    logic in_last;
    logic tally_full;
    logic last_q;
    logic tally_zero;
    logic div_done;
    logic over;
    logic srch_done;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

FILE: rtl/wind_vane_direction_estimator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wind_vane_direction_estimator_core
// Batch filter and 16-point resistor-ladder wind vane decoder.
// ----------------------------------------------------------------------------
// A table write is done on acceptance; a sample is a load with the feedback
// multiply, then the filter update and accumulate. The last sample of a batch
// adds the evaluation: the mean-voltage division (start, 39 steps of the
// restoring divider at one bit a cycle, done), the resistance division
// unless the mean reaches the supply, a table search through the registered
// table read and the load steps. A stalled result slot holds the sequencer
// until it frees. The result sits in an output register; a new batch may
// start while it waits.
module wind_vane_direction_estimator_core
  import wvde_pkg::*;
#(
  parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
  parameter int DIRECTIONS  = DEF_DIRECTIONS
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_item_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_item_t                 out_data
);

  cmd_t  cmd;
  stat_t st;

  wvde_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  wvde_datapath #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .DIRECTIONS  (DIRECTIONS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .st        (st)
  );

endmodule
`default_nettype wire

FILE: rtl/wvde_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wvde_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
module wvde_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/wvde_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wvde_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wvde_div #(
  parameter int N_W = 39,
  parameter int D_W = 23
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire logic [N_W-1:0] num,
  input  wire logic [D_W-1:0] den,
  output logic                done,
  output logic      [N_W-1:0] quot
);

  localparam int CNT_W = $clog2(N_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [D_W-1:0]   rem;
  logic [D_W-1:0]   dreg;
  logic [D_W:0]     trial;
  logic             fits;

  always_comb begin
    trial = {rem, quot[N_W-1]};
    fits  = trial >= {1'b0, dreg};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(N_W);
        rem  <= '0;
        quot <= num;
        dreg <= den;
      end else if (busy) begin
        if (fits) begin
          rem <= D_W'(trial - {1'b0, dreg});
        end else begin
          rem <= trial[D_W-1:0];
        end
        quot <= {quot[N_W-2:0], fits};
        cnt  <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/wvde_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wvde_datapath
// Filter, accumulator, mean and resistance math, table search, output slot.
// ----------------------------------------------------------------------------
module wvde_datapath
  import wvde_pkg::*;
#(
  parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
  parameter int DIRECTIONS  = DEF_DIRECTIONS
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire in_item_t             in_data,
  output out_item_t                 out_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  input  wire cmd_t                 cmd,
  output stat_t                     st
);

  localparam int TALLY_W = $clog2(MAX_SAMPLES + 1);
  localparam int DEN_W   = FS_W + TALLY_W;

  logic [RES_W-1:0]    r_ohms;
  logic [SUPPLY_W-1:0] supply;
  logic [SUPPLY_W-1:0] refmv;
  logic [FS_W-1:0]     fs;

  logic [SAMPLE_W-1:0] xcur;
  logic [SAMPLE_W-1:0] xprev;
  logic [MV_W-1:0]     yprev;
  logic [SUM_W-1:0]    sum;
  logic [TALLY_W-1:0]  tally;
  logic                last_q;
  logic [PROD_W-1:0]   prod;
  logic [NUM_W-1:0]    num;
  logic [DEN_W-1:0]    den;
  logic [MV_W-1:0]     mv;
  logic                over;
  logic [OHMS_W-1:0]   ohms;
  logic [OHMS_W-1:0]   best;
  logic [IDX_W-1:0]    idx;
  logic [SCNT_W-1:0]   scnt;

  logic [SAMPLE_W:0]   xsum;
  logic signed [32:0]  acc;
  logic [17:0]         yraw;
  logic [MV_W-1:0]     y;
  logic [FS_W-1:0]     fs_eff;
  logic [MV_W-1:0]     mv_sat;
  logic [OHMS_W-1:0]   ohms_sat;
  logic [OHMS_W-1:0]   entry;
  logic [OHMS_W-1:0]   delta;
  logic [SUPPLY_W-1:0] headroom;
  logic [RES_W+MV_W-1:0] ohms_prod;
  logic                div_done;
  logic [NUM_W-1:0]    quot;

  wvde_ram #(.WIDTH(OHMS_W), .DEPTH(ENTRIES)) u_table (
    .clk   (clk),
    .we    (cmd.tbl_we),
    .waddr (in_data.entry_index),
    .wdata (in_data.entry_ohms),
    .raddr (scnt[IDX_W-1:0]),
    .rdata (entry)
  );

  wvde_div #(.N_W(NUM_W), .D_W(DEN_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .quot  (quot)
  );

  always_comb begin
    xsum     = {1'b0, xcur} + {1'b0, xprev};
    acc      = $signed({5'b0, xsum, 15'b0}) - $signed({2'b0, prod});
    yraw     = acc[32:15];
    if (acc <= 0) begin
      y = '0;
    end else if (yraw > {2'b0, MV_MAX}) begin
      y = MV_MAX;
    end else begin
      y = yraw[MV_W-1:0];
    end
    fs_eff   = (fs == '0) ? FS_W'(1) : fs;
    mv_sat   = (quot > NUM_W'(MV_MAX)) ? MV_MAX : quot[MV_W-1:0];
    ohms_sat = (quot > NUM_W'(OHMS_MAX)) ? OHMS_MAX : quot[OHMS_W-1:0];
    delta    = (ohms >= entry) ? ohms - entry : entry - ohms;
    headroom = supply - mv[SUPPLY_W-1:0];
    ohms_prod = r_ohms * mv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_ohms <= RES_W'(10000);
      supply <= SUPPLY_W'(3300);
      refmv  <= SUPPLY_W'(3300);
      fs     <= FS_W'(4095);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SERIES: r_ohms <= cfg_data[RES_W-1:0];
        CFG_SUPPLY: supply <= cfg_data[SUPPLY_W-1:0];
        CFG_REF:    refmv  <= cfg_data[SUPPLY_W-1:0];
        CFG_FS:     fs     <= cfg_data[FS_W-1:0];
        default:    ;
      endcase
    end
  end

  // batch state: cleared at reset and when a result is loaded
  always_ff @(posedge clk) begin
    if (rst || cmd.out_load) begin
      xprev <= '0;
      yprev <= '0;
      sum   <= '0;
      tally <= '0;
    end else if (cmd.filt_acc) begin
      xprev <= xcur;
      yprev <= y;
      sum   <= sum + SUM_W'(y);
      tally <= tally + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.smp_load) begin
      xcur   <= in_data.sample_code;
      last_q <= in_data.last_sample;
      prod   <= A1_Q15 * yprev;
    end
    if (cmd.mean_mul) begin
      num <= refmv * sum;
      den <= fs_eff * tally;
    end
    if (cmd.mean_load) begin
      mv   <= st.tally_zero ? '0 : mv_sat;
      over <= (st.tally_zero ? '0 : mv_sat) >= MV_W'(supply);
      ohms <= OHMS_MAX;
      idx  <= '0;
    end
    if (cmd.ohms_mul) begin
      num <= NUM_W'(ohms_prod);
      den <= DEN_W'(headroom);
    end
    if (cmd.ohms_load) begin
      ohms <= ohms_sat;
      scnt <= '0;
    end
    if (cmd.srch_step) begin
      scnt <= scnt + 1'b1;
      // entry read last cycle belongs to index scnt-1
      if (scnt != '0 && (scnt == SCNT_W'(1) || delta < best)) begin
        best <= delta;
        idx  <= IDX_W'(scnt - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.mean_millivolts  <= mv;
      out_data.vane_ohms        <= ohms;
      out_data.direction_index  <= idx;
      out_data.direction_tenths <= idx * TENTHS_PER_STEP;
      out_data.over_supply      <= over;
    end
  end

  always_comb begin
    st.in_kind    = in_data.kind;
    st.in_last    = in_data.last_sample;
    st.tally_full = tally == TALLY_W'(MAX_SAMPLES);
    st.last_q     = last_q;
    st.tally_zero = tally == '0;
    st.div_done   = div_done;
    st.over       = over;
    st.srch_done  = scnt == SCNT_W'(DIRECTIONS);
    st.out_free   = !out_valid || !out_stall;
  end

endmodule
`default_nettype wire

FILE: rtl/wvde_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wvde_ctrl
// Sequencer for sample filtering and end-of-batch evaluation.
// ----------------------------------------------------------------------------
module wvde_ctrl
  import wvde_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_stall,
  input  wire stat_t st,
  output cmd_t       cmd
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_FACC      = 4'd1;
  localparam logic [3:0] S_MMUL      = 4'd2;
  localparam logic [3:0] S_MDIV_GO   = 4'd3;
  localparam logic [3:0] S_MDIV_WAIT = 4'd4;
  localparam logic [3:0] S_MEAN      = 4'd5;
  localparam logic [3:0] S_OMUL      = 4'd6;
  localparam logic [3:0] S_ODIV_GO   = 4'd7;
  localparam logic [3:0] S_ODIV_WAIT = 4'd8;
  localparam logic [3:0] S_OHMS      = 4'd9;
  localparam logic [3:0] S_SRCH      = 4'd10;
  localparam logic [3:0] S_DONE      = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       accept;

  assign in_stall = state != S_IDLE;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (st.in_kind == KIND_ENTRY) begin
            cmd.tbl_we = 1'b1;
          end else if (!st.tally_full) begin
            cmd.smp_load = 1'b1;
            state_next   = S_FACC;
          end else if (st.in_last) begin
            // drop the sample but still close the batch
            state_next = S_MMUL;
          end
        end
      end
      S_FACC: begin
        cmd.filt_acc = 1'b1;
        state_next   = st.last_q ? S_MMUL : S_IDLE;
      end
      S_MMUL: begin
        cmd.mean_mul = 1'b1;
        state_next   = st.tally_zero ? S_MEAN : S_MDIV_GO;
      end
      S_MDIV_GO: begin
        cmd.div_start = 1'b1;
        state_next    = S_MDIV_WAIT;
      end
      S_MDIV_WAIT: begin
        if (st.div_done) begin
          state_next = S_MEAN;
        end
      end
      S_MEAN: begin
        cmd.mean_load = 1'b1;
        state_next    = S_OMUL;
      end
      S_OMUL: begin
        if (st.over) begin
          state_next = S_DONE;
        end else begin
          cmd.ohms_mul = 1'b1;
          state_next   = S_ODIV_GO;
        end
      end
      S_ODIV_GO: begin
        cmd.div_start = 1'b1;
        state_next    = S_ODIV_WAIT;
      end
      S_ODIV_WAIT: begin
        if (st.div_done) begin
          state_next = S_OHMS;
        end
      end
      S_OHMS: begin
        cmd.ohms_load = 1'b1;
        state_next    = S_SRCH;
      end
      S_SRCH: begin
        cmd.srch_step = 1'b1;
        if (st.srch_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_start_pulse: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> !cmd.div_start)
    else $error("divider start held for more than one cycle");

  a_done_to_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && st.out_free) |=> state == S_IDLE)
    else $error("result slot free but sequencer did not return to idle");

  a_load_single: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> !cmd.out_load)
    else $error("result loaded twice for one batch");

endmodule
`default_nettype wire
